/* rtl/core/ipv4_forwarding_classifier_defines.svh */
// Assertion macros for the classifier RTL.
// Expects clk and rst_n in the scope of the module that expands them.
`ifndef IPV4_FORWARDING_CLASSIFIER_DEFINES_SVH
`define IPV4_FORWARDING_CLASSIFIER_DEFINES_SVH

// hold cons in the same cycle as ante
`define IFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// hold cons in the cycle after ante
`define IFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ifc_pkg.sv */
// Package for the IPv4 forwarding classifier: sizes, codes, beat structs
// and the byte leading-zero helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ifc_pkg;

  localparam int ROUTE_ENTRIES = 16;
  localparam int PORT_ENTRIES  = 8;

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int PORT_W = 3;
  localparam int HOP_W  = 8;
  localparam int SLOT_W = 4;
  localparam int PSLOT_BITS = 3;

  localparam int RIDX_W  = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int PIDX_W  = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
  localparam int RSLOT_W = (RIDX_W > SLOT_W) ? RIDX_W : SLOT_W;
  localparam int PSLOT_W = (PIDX_W > PSLOT_BITS) ? PIDX_W : PSLOT_BITS;

  localparam int SCAN_TOTAL = PORT_ENTRIES + ROUTE_ENTRIES;
  localparam int CNT_W      = $clog2(SCAN_TOTAL + 1);

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;

  localparam logic [7:0] PROTO_ICMP    = 8'd1;
  localparam logic [7:0] PROTO_TCP     = 8'd6;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;

  typedef enum logic [1:0] {
    OP_ROUTE    = 2'd0,
    OP_PORT     = 2'd1,
    OP_CLASSIFY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE          = 3'd0,
    ACT_ECHO          = 3'd1,
    ACT_PORT_UNREACH  = 3'd2,
    ACT_NET_UNREACH   = 3'd3,
    ACT_TIME_EXCEEDED = 3'd4,
    ACT_FORWARD       = 3'd5
  } action_t;

  typedef struct packed {
    logic              route_we;
    logic              port_we;
    logic [RIDX_W-1:0] raddr;
    logic [PIDX_W-1:0] paddr;
    logic [ADDR_W-1:0] data;
    logic [PORT_W-1:0] egress;
    logic              enable;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic              is_port;
    logic [PIDX_W-1:0] paddr;
    logic [RIDX_W-1:0] raddr;
    logic              last;
  } rd_req_t;

  typedef struct packed {
    logic              vld;
    logic              is_port;
    logic              ent_valid;
    logic              last;
    logic [PORT_W-1:0] egress;
    logic [ADDR_W-1:0] data;
  } rd_beat_t;

  typedef struct packed {
    logic              vld;
    logic              is_port;
    logic              ent_valid;
    logic              last;
    logic [PORT_W-1:0] egress;
    logic [LEN_W-1:0]  len;
  } pu_res_t;

  // leading zeros of a non-zero byte
  function automatic logic [2:0] lzc8(input logic [7:0] v);
    logic [2:0] n;
    logic       found;
    n     = 3'd0;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) begin
          found = 1'b1;
        end else begin
          n = n + 3'd1;
        end
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ifc_tables.sv */
// Route and interface tables: one write port, one registered read port.
// Depends on ifc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ifc_tables (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ifc_pkg::wr_req_t wr,
  input  wire ifc_pkg::rd_req_t rd,
  output ifc_pkg::rd_beat_t     q
);
  import ifc_pkg::*;

  logic [ADDR_W-1:0] route_mem [ROUTE_ENTRIES];
  logic [PORT_W-1:0] egress_mem [ROUTE_ENTRIES];
  logic [ADDR_W-1:0] port_mem [PORT_ENTRIES];
  logic              route_valid_r [ROUTE_ENTRIES];
  logic              port_valid_r [PORT_ENTRIES];

  logic              q_vld_r;
  logic              q_is_port_r;
  logic              q_last_r;
  logic              q_ent_valid_r;
  logic [PORT_W-1:0] q_egress_r;
  logic [ADDR_W-1:0] q_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
        route_valid_r[i] <= 1'b0;
      end
      for (int i = 0; i < PORT_ENTRIES; i++) begin
        port_valid_r[i] <= 1'b0;
      end
      q_vld_r <= 1'b0;
    end else begin
      if (wr.route_we) begin
        route_valid_r[wr.raddr] <= wr.enable;
      end
      if (wr.port_we) begin
        port_valid_r[wr.paddr] <= wr.enable;
      end
      q_vld_r <= rd.en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.route_we) begin
      route_mem[wr.raddr]  <= wr.data;
      egress_mem[wr.raddr] <= wr.egress;
    end
    if (wr.port_we) begin
      port_mem[wr.paddr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    q_is_port_r <= rd.is_port;
    q_last_r    <= rd.last;
    if (rd.is_port) begin
      q_data_r      <= port_mem[rd.paddr];
      q_egress_r    <= '0;
      q_ent_valid_r <= port_valid_r[rd.paddr];
    end else begin
      q_data_r      <= route_mem[rd.raddr];
      q_egress_r    <= egress_mem[rd.raddr];
      q_ent_valid_r <= route_valid_r[rd.raddr];
    end
  end

  assign q = '{vld:       q_vld_r,
               is_port:   q_is_port_r,
               ent_valid: q_ent_valid_r,
               last:      q_last_r,
               egress:    q_egress_r,
               data:      q_data_r};

endmodule

`default_nettype wire

/* rtl/core/ifc_prefix_unit.sv */
// Shared two-stage common-prefix counter: byte leading zeros, then merge.
// Depends on ifc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ifc_prefix_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ifc_pkg::rd_beat_t         ent,
  input  wire logic [ifc_pkg::ADDR_W-1:0] key,
  output ifc_pkg::pu_res_t               res
);
  import ifc_pkg::*;

  localparam int NBYTES = ADDR_W / 8;

  logic [ADDR_W-1:0] diff;
  logic              s1_vld_r;
  logic              s1_is_port_r;
  logic              s1_ent_valid_r;
  logic              s1_last_r;
  logic [PORT_W-1:0] s1_egress_r;
  logic [NBYTES-1:0] s1_zero_r;
  logic [2:0]        s1_lz_r [NBYTES];
  logic [LEN_W-1:0]  len_nxt;
  pu_res_t           res_r;

  assign diff = ent.data ^ key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      res_r.vld <= 1'b0;
    end else begin
      s1_vld_r  <= ent.vld;
      res_r.vld <= s1_vld_r;
    end
    s1_is_port_r   <= ent.is_port;
    s1_ent_valid_r <= ent.ent_valid;
    s1_last_r      <= ent.last;
    s1_egress_r    <= ent.egress;
    for (int k = 0; k < NBYTES; k++) begin
      s1_zero_r[k] <= (diff[ADDR_W-1-8*k -: 8] == 8'd0);
      s1_lz_r[k]   <= lzc8(diff[ADDR_W-1-8*k -: 8]);
    end
    res_r.is_port   <= s1_is_port_r;
    res_r.ent_valid <= s1_ent_valid_r;
    res_r.last      <= s1_last_r;
    res_r.egress    <= s1_egress_r;
    res_r.len       <= len_nxt;
  end

  // first differing byte from the top sets the length
  always_comb begin
    len_nxt = LEN_W'(ADDR_W);
    for (int k = NBYTES - 1; k >= 0; k--) begin
      if (!s1_zero_r[k]) begin
        len_nxt = LEN_W'(8 * k) + LEN_W'(s1_lz_r[k]);
      end
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

/* rtl/core/ipv4_forwarding_classifier.sv */
// IPv4 forwarding classifier: sequencer, decision logic and output register.
// Uses ifc_pkg, ifc_tables, ifc_prefix_unit and the classifier defines header.
// Table writes (tuser 0 route, 1 interface) and the unused code return one
// all-zero result beat. A classify beat (tuser 2) visits every interface
// entry and then every route entry, one per cycle, through the single table
// read port and the shared prefix counter; their three pipeline stages are
// passed before the result load. in_tready is low during a classify.
// The result sits in an output register and in_tready stays low while it
// waits on out_tready, so the next beat is taken at the earliest in the cycle
// that result leaves.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_forwarding_classifier (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // slot, address, egress, enable, protocol, hop_limit, message_type
  input  wire logic [ifc_pkg::IN_TDATA_W-1:0] in_tdata,
  // op
  input  wire logic [1:0]                     in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // out_port, new_hop_limit, match_length, zero fill
  output logic [ifc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // action
  output logic [2:0]                          out_tuser
);
  import ifc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] dest_r, dest_nxt;
  logic [7:0]        proto_r, proto_nxt;
  logic [HOP_W-1:0]  hop_r, hop_nxt;
  logic [7:0]        mtype_r, mtype_nxt;
  logic              local_r, local_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;
  logic [PORT_W-1:0] best_port_r, best_port_nxt;
  logic              out_vld_r, out_vld_nxt;
  action_t           out_act_r, out_act_nxt;
  logic [PORT_W-1:0] out_port_r, out_port_nxt;
  logic [HOP_W-1:0]  out_hop_r, out_hop_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  logic              in_fire;
  logic              out_free;
  op_t               op;
  logic [SLOT_W-1:0] in_slot;
  logic [RSLOT_W-1:0] rslot;
  logic [PSLOT_W-1:0] pslot;
  logic [CNT_W-1:0]  rsub;
  wr_req_t           wr;
  rd_req_t           rd;
  rd_beat_t          ent;
  pu_res_t           pres;

  assign op      = op_t'(in_tuser);
  assign in_slot = in_tdata[3:0];
  assign rslot   = RSLOT_W'(in_slot);
  assign pslot   = PSLOT_W'(in_slot[PSLOT_BITS-1:0]);
  assign rsub    = cnt_r - CNT_W'(PORT_ENTRIES);

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    wr.route_we = in_fire && (op == OP_ROUTE) && (int'(rslot) < ROUTE_ENTRIES);
    wr.port_we  = in_fire && (op == OP_PORT) && (int'(pslot) < PORT_ENTRIES);
    wr.raddr    = rslot[RIDX_W-1:0];
    wr.paddr    = pslot[PIDX_W-1:0];
    wr.data     = in_tdata[35:4];
    wr.egress   = in_tdata[38:36];
    wr.enable   = in_tdata[39];
  end

  always_comb begin
    rd.en      = (state_r == S_SCAN);
    rd.is_port = (cnt_r < CNT_W'(PORT_ENTRIES));
    rd.paddr   = cnt_r[PIDX_W-1:0];
    rd.raddr   = rsub[RIDX_W-1:0];
    rd.last    = (cnt_r == CNT_W'(SCAN_TOTAL - 1));
  end

  ifc_tables u_tables (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .rd    (rd),
    .q     (ent)
  );

  ifc_prefix_unit u_prefix (
    .clk   (clk),
    .rst_n (rst_n),
    .ent   (ent),
    .key   (dest_r),
    .res   (pres)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    dest_nxt      = dest_r;
    proto_nxt     = proto_r;
    hop_nxt       = hop_r;
    mtype_nxt     = mtype_r;
    local_nxt     = local_r;
    best_len_nxt  = best_len_r;
    best_port_nxt = best_port_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_act_nxt   = out_act_r;
    out_port_nxt  = out_port_r;
    out_hop_nxt   = out_hop_r;
    out_len_nxt   = out_len_r;

    // fold in one scanned entry
    if (pres.vld && pres.ent_valid) begin
      if (pres.is_port) begin
        if (pres.len == LEN_W'(ADDR_W)) begin
          local_nxt = 1'b1;
        end
      end else if (pres.len > best_len_r) begin
        best_len_nxt  = pres.len;
        best_port_nxt = pres.egress;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (op == OP_CLASSIFY) begin
            dest_nxt      = in_tdata[35:4];
            proto_nxt     = in_tdata[47:40];
            hop_nxt       = in_tdata[55:48];
            mtype_nxt     = in_tdata[63:56];
            local_nxt     = 1'b0;
            best_len_nxt  = '0;
            best_port_nxt = '0;
            cnt_nxt       = '0;
            state_nxt     = S_SCAN;
          end else begin
            out_vld_nxt  = 1'b1;
            out_act_nxt  = ACT_NONE;
            out_port_nxt = '0;
            out_hop_nxt  = '0;
            out_len_nxt  = '0;
          end
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (rd.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (pres.vld && pres.last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_port_nxt = '0;
          out_hop_nxt  = hop_r;
          out_len_nxt  = '0;
          out_act_nxt  = ACT_NONE;
          if (local_r) begin
            if (proto_r == PROTO_ICMP) begin
              if (mtype_r == ICMP_ECHO_REQ) begin
                out_act_nxt = ACT_ECHO;
              end
            end else if (proto_r == PROTO_TCP || proto_r == PROTO_UDP) begin
              out_act_nxt = ACT_PORT_UNREACH;
            end
          end else if (best_len_r == '0) begin
            out_act_nxt = ACT_NET_UNREACH;
          end else begin
            out_len_nxt = best_len_r;
            if (hop_r <= HOP_W'(1)) begin
              out_act_nxt = ACT_TIME_EXCEEDED;
            end else begin
              out_act_nxt  = ACT_FORWARD;
              out_port_nxt = best_port_r;
              out_hop_nxt  = hop_r - HOP_W'(1);
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      cnt_r     <= cnt_nxt;
    end
    dest_r      <= dest_nxt;
    proto_r     <= proto_nxt;
    hop_r       <= hop_nxt;
    mtype_r     <= mtype_nxt;
    local_r     <= local_nxt;
    best_len_r  <= best_len_nxt;
    best_port_r <= best_port_nxt;
    out_act_r   <= out_act_nxt;
    out_port_r  <= out_port_nxt;
    out_hop_r   <= out_hop_nxt;
    out_len_r   <= out_len_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_act_r;
  assign out_tdata  = {(OUT_TDATA_W - PORT_W - HOP_W - LEN_W)'(0),
                       out_len_r, out_hop_r, out_port_r};

`include "ipv4_forwarding_classifier_defines.svh"

  `IFC_ASSERT_NEXT(a_classify_blocks, in_fire && (op == OP_CLASSIFY), !in_tready, "classify beat did not block input")
  `IFC_ASSERT_NOW(a_pu_in_scan, pres.vld, (state_r == S_SCAN) || (state_r == S_DRAIN), "prefix result outside scan")
  `IFC_ASSERT_NOW(a_fwd_len, out_vld_r && (out_act_r == ACT_FORWARD), (out_len_r != '0) && (out_hop_r != 8'hFF), "forward with no match or hop underflow")
  `IFC_ASSERT_NOW(a_len_range, out_vld_r, out_len_r <= LEN_W'(ADDR_W), "match length beyond address width")

endmodule

`default_nettype wire

/* bench/ipv4_forwarding_classifier_test.sv */
// Self-checking bench for ipv4_forwarding_classifier: route and interface
// table loads, unused-code beats, classify headers, predicted decisions checked beat by beat.
// Depends on ifc_pkg and the classifier RTL only.
`timescale 1ns / 1ps

import ifc_pkg::*;

typedef struct packed {
  action_t          act;
  logic [PORT_W-1:0] port;
  logic [HOP_W-1:0]  hop;
  logic [LEN_W-1:0]  len;
} decision_t;

class route_decision_scoreboard;
  logic [ADDR_W-1:0] route_dst [ROUTE_ENTRIES];
  logic [PORT_W-1:0] route_egr [ROUTE_ENTRIES];
  bit                route_ok  [ROUTE_ENTRIES];
  logic [ADDR_W-1:0] if_addr   [PORT_ENTRIES];
  bit                if_ok     [PORT_ENTRIES];
  decision_t         pending_decisions[$];
  int                errors;
  int                beats_in;
  int                checked;
  int                writes;
  int                tally [8];

  function new();
    foreach (route_ok[i]) route_ok[i] = 1'b0;
    foreach (if_ok[i]) if_ok[i] = 1'b0;
    foreach (tally[i]) tally[i] = 0;
    errors   = 0;
    beats_in = 0;
    checked  = 0;
    writes   = 0;
  endfunction

  function int pending();
    return pending_decisions.size();
  endfunction

  function void note_header_beat(logic [1:0] op, logic [IN_TDATA_W-1:0] data);
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] diff;
    logic [PORT_W-1:0] egr;
    logic              en;
    logic [7:0]        proto;
    logic [HOP_W-1:0]  hops;
    logic [7:0]        mtype;
    decision_t         d;
    bit                local_hit;
    int                best;
    int                best_idx;
    int                n;
    slot  = data[3:0];
    addr  = data[35:4];
    egr   = data[38:36];
    en    = data[39];
    proto = data[47:40];
    hops  = data[55:48];
    mtype = data[63:56];
    d     = '{ACT_NONE, '0, '0, '0};
    beats_in++;
    case (op)
      OP_ROUTE: begin
        writes++;
        if (slot < ROUTE_ENTRIES) begin
          route_dst[slot] = addr;
          route_egr[slot] = egr;
          route_ok[slot]  = en;
        end
      end
      OP_PORT: begin
        writes++;
        if (slot[PSLOT_BITS-1:0] < PORT_ENTRIES) begin
          if_addr[slot[PSLOT_BITS-1:0]] = addr;
          if_ok[slot[PSLOT_BITS-1:0]]   = en;
        end
      end
      OP_CLASSIFY: begin
        d.hop     = hops;
        local_hit = 1'b0;
        for (int i = 0; i < PORT_ENTRIES; i++) begin
          if (if_ok[i] && if_addr[i] == addr) local_hit = 1'b1;
        end
        if (local_hit) begin
          if (proto == PROTO_ICMP) begin
            if (mtype == ICMP_ECHO_REQ) d.act = ACT_ECHO;
          end else if (proto == PROTO_TCP || proto == PROTO_UDP) begin
            d.act = ACT_PORT_UNREACH;
          end
        end else begin
          best     = 0;
          best_idx = 0;
          for (int i = 0; i < ROUTE_ENTRIES; i++) begin
            if (route_ok[i]) begin
              diff = route_dst[i] ^ addr;
              n    = 0;
              while (n < ADDR_W && !diff[ADDR_W-1-n]) n++;
              if (n > best) begin
                best     = n;
                best_idx = i;
              end
            end
          end
          if (best == 0) begin
            d.act = ACT_NET_UNREACH;
          end else begin
            d.len = best[LEN_W-1:0];
            if (hops <= 1) begin
              d.act = ACT_TIME_EXCEEDED;
            end else begin
              d.act  = ACT_FORWARD;
              d.port = route_egr[best_idx];
              d.hop  = hops - 8'd1;
            end
          end
        end
        tally[d.act]++;
      end
      default: ;
    endcase
    pending_decisions.push_back(d);
  endfunction

  function void mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
    if (errors < 40) $error("%s: expected %0d, got %0d", field, exp_v, got_v);
    errors++;
  endfunction

  function void check_decision_beat(logic [2:0] act, logic [OUT_TDATA_W-1:0] data);
    decision_t d;
    if (pending_decisions.size() == 0) begin
      if (errors < 40) $error("result beat with no decision pending, action %0d", act);
      errors++;
      return;
    end
    d = pending_decisions.pop_front();
    checked++;
    if (act !== d.act) mismatch("action", d.act, act);
    if (data[2:0] !== d.port) mismatch("out_port", d.port, data[2:0]);
    if (data[10:3] !== d.hop) mismatch("new_hop_limit", d.hop, data[10:3]);
    if (data[16:11] !== d.len) mismatch("match_length", d.len, data[16:11]);
  endfunction
endclass

module ipv4_forwarding_classifier_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 40;
  localparam int PHASE_ITEMS    = 330;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [1:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]             out_tuser;

  route_decision_scoreboard sb;

  logic [ADDR_W-1:0] shadow_rt [ROUTE_ENTRIES];
  logic [ADDR_W-1:0] shadow_if [PORT_ENTRIES];
  int idle_cycles = 0;
  int cyc         = 0;
  int stall_left  = 0;
  int burst_left  = 0;
  bit steady      = 1'b0;

  ipv4_forwarding_classifier DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_decision_beat(out_tuser, out_tdata);
      if (in_tvalid && in_tready) sb.note_header_beat(in_tuser, in_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: rotate between always ready, coin flips, a fixed pattern and long stalls
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case ((cyc / 400) % 4)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (cyc % 5) > 1;
        default: begin
          if ($urandom_range(0, 49) == 0) begin
            stall_left <= $urandom_range(5, 60);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic push_beat(input logic [1:0] op, input logic [IN_TDATA_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!steady && $urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 12);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [IN_TDATA_W-1:0] pack_header(
      logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] egr,
      logic en, logic [7:0] proto, logic [HOP_W-1:0] hops, logic [7:0] mtype);
    return {mtype, hops, proto, en, egr, addr, slot};
  endfunction

  task automatic route_write(input logic [SLOT_W-1:0] slot, input logic [ADDR_W-1:0] dst,
                             input logic [PORT_W-1:0] egr, input logic en);
    if (slot < ROUTE_ENTRIES) shadow_rt[slot] = dst;
    push_beat(OP_ROUTE, pack_header(slot, dst, egr, en, 8'($urandom), 8'($urandom),
                                    8'($urandom)));
  endtask

  task automatic iface_write(input logic [SLOT_W-1:0] slot, input logic [ADDR_W-1:0] addr,
                             input logic en);
    shadow_if[slot[PSLOT_BITS-1:0]] = addr;
    push_beat(OP_PORT, pack_header(slot, addr, 3'($urandom), en, 8'($urandom), 8'($urandom),
                                   8'($urandom)));
  endtask

  task automatic classify(input logic [ADDR_W-1:0] dst, input logic [7:0] proto,
                          input logic [HOP_W-1:0] hops, input logic [7:0] mtype);
    push_beat(OP_CLASSIFY, pack_header(4'($urandom), dst, 3'($urandom), 1'($urandom),
                                       proto, hops, mtype));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // destination near a stored route, on an interface, or anywhere
  function automatic logic [ADDR_W-1:0] pick_dest();
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] m;
    int k;
    case ($urandom_range(0, 9))
      0, 1: return shadow_if[$urandom_range(0, PORT_ENTRIES-1)];
      2, 3, 4, 5, 6: begin
        base = shadow_rt[$urandom_range(0, ROUTE_ENTRIES-1)];
        k = $urandom_range(0, ADDR_W);
        if (k == ADDR_W) return base;
        m = 32'h1 << k;
        return (base ^ m) ^ ($urandom & (m - 32'h1));
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_route_dest(int policy);
    logic [ADDR_W-1:0] a;
    int choice;
    choice = $urandom_range(0, 3);
    if (policy == 3 && choice > 1) choice = 0;
    case (choice)
      0: a = shadow_rt[$urandom_range(0, ROUTE_ENTRIES-1)];
      1: a = shadow_rt[$urandom_range(0, ROUTE_ENTRIES-1)] ^ ($urandom >> $urandom_range(1, 31));
      default: a = $urandom;
    endcase
    if (policy == 1) a[ADDR_W-1] = 1'b0;
    return a;
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 4))
      0, 4: return PROTO_ICMP;
      1: return PROTO_TCP;
      2: return PROTO_UDP;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [HOP_W-1:0] pick_hops();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int r;
    sb = new();
    foreach (shadow_rt[i]) shadow_rt[i] = '0;
    foreach (shadow_if[i]) shadow_if[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    classify(32'h0000_0000, PROTO_TCP, 8'd64, 8'd0);
    iface_write(4'd0, 32'h0A00_0001, 1'b1);
    iface_write(4'd15, 32'hFFFF_FFFF, 1'b1);
    route_write(4'd0, 32'h0A00_0000, 3'd1, 1'b1);
    route_write(4'd15, 32'hC0A8_0100, 3'd7, 1'b1);
    route_write(4'd3, 32'h0A00_0000, 3'd2, 1'b1);
    classify(32'h0A00_0001, PROTO_ICMP, 8'd64, ICMP_ECHO_REQ);
    classify(32'h0A00_0001, PROTO_ICMP, 8'd64, 8'd0);
    classify(32'h0A00_0001, PROTO_TCP, 8'd1, 8'd0);
    classify(32'h0A00_0001, PROTO_UDP, 8'd0, 8'd0);
    classify(32'h0A00_0001, 8'hFF, 8'd9, ICMP_ECHO_REQ);
    classify(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
    classify(32'h0A00_00FF, PROTO_UDP, 8'd2, 8'd0);
    classify(32'hC0A8_0100, PROTO_TCP, 8'd1, 8'd0);
    classify(32'hC0A8_0100, PROTO_TCP, 8'd0, 8'd0);
    classify(32'h8000_0000, PROTO_ICMP, 8'd255, ICMP_ECHO_REQ);
    route_write(4'd15, 32'hC0A8_0100, 3'd7, 1'b0);
    classify(32'h8000_0000, PROTO_ICMP, 8'd255, ICMP_ECHO_REQ);
    iface_write(4'd0, 32'h0A00_0001, 1'b0);
    classify(32'h0A00_0001, PROTO_ICMP, 8'd10, ICMP_ECHO_REQ);
    push_beat(OP_UNUSED, '1);
    push_beat(OP_UNUSED, '0);
    route_write(4'd7, 32'hFFFF_FFFF, 3'd5, 1'b1);
    iface_write(4'd8, 32'h1234_5678, 1'b1);

    // each phase: drain, reload both tables, then mixed traffic
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      steady = (ph == 3);
      for (int s = 0; s < ROUTE_ENTRIES; s++) begin
        route_write(4'(s), pick_route_dest(ph), 3'($urandom),
                    $urandom_range(0, 99) < ((ph == 2) ? 25 : 85));
      end
      for (int s = 0; s < PORT_ENTRIES; s++) begin
        iface_write(4'($urandom_range(0, 1) * 8 + s), $urandom, $urandom_range(0, 9) < 6);
      end
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          route_write(4'($urandom), pick_route_dest(ph), 3'($urandom),
                      $urandom_range(0, 99) < 80);
        end else if (r < 18) begin
          iface_write(4'($urandom), ($urandom_range(0, 1) != 0) ? pick_dest() : $urandom,
                      $urandom_range(0, 3) != 0);
        end else if (r < 20) begin
          push_beat(OP_UNUSED, {$urandom, $urandom});
        end else if (r < 25) begin
          classify($urandom, 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          classify(pick_dest(), pick_proto(), pick_hops(),
                   ($urandom_range(0, 1) != 0) ? ICMP_ECHO_REQ : 8'($urandom));
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d beats (%0d table writes), %0d decisions checked.",
             sb.beats_in, sb.writes, sb.checked);
    $display("Classify outcomes: drop %0d, echo %0d, port unreach %0d, net unreach %0d, ",
             sb.tally[ACT_NONE], sb.tally[ACT_ECHO], sb.tally[ACT_PORT_UNREACH],
             sb.tally[ACT_NET_UNREACH], "ttl expired %0d, forward %0d",
             sb.tally[ACT_TIME_EXCEEDED], sb.tally[ACT_FORWARD]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ifc_pkg.sv
rtl/core/ifc_tables.sv
rtl/core/ifc_prefix_unit.sv
rtl/core/ipv4_forwarding_classifier.sv
bench/ipv4_forwarding_classifier_test.sv
